@@ rtl/core/sravm_pkg.sv @@
// ----------------------------------------------------------------------------
// sravm_pkg
// Shared types and constants of the sensor running average monitor: result
// codes, controller states, command and status bundles, register map.
// ----------------------------------------------------------------------------
package sravm_pkg;

	localparam int DATA_W           = 16;
	localparam int DEF_MAX_SENSORS  = 32;
	localparam int DEF_WINDOW       = 8;

	localparam int CFG_ADDR_W       = 3;
	localparam int CFG_DATA_W       = 32;
	localparam logic [DATA_W-1:0] MIN_TEMP_RST = 16'h1200;
	localparam logic [DATA_W-1:0] MAX_TEMP_RST = 16'h1900;

	// register select is address bit 2
	localparam logic REG_MIN_TEMP   = 1'b0;
	localparam logic REG_MAX_TEMP   = 1'b1;

	localparam logic ACT_ADD        = 1'b0;

	typedef enum logic [2:0] {
		ST_NORMAL  = 3'd0,
		ST_COLD    = 3'd1,
		ST_HOT     = 3'd2,
		ST_UNKNOWN = 3'd3,
		ST_ADDED   = 3'd4,
		ST_FULL    = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		RES_ADDED,
		RES_FULL,
		RES_UNKNOWN,
		RES_WARMUP,
		RES_AVG
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_RD_ST,
		S_RD_SMP,
		S_UPD,
		S_DIV_INIT,
		S_DIV,
		S_OUT
	} ctl_state_t;

	typedef struct packed {
		logic capture;
		logic add_write;
		logic scan_next;
		logic take_room;
		logic take_state;
		logic upd;
		logic div_init;
		logic div_step;
		logic load_out;
		res_t res;
	} cmd_t;

	typedef struct packed {
		logic action;
		logic full;
		logic count_zero;
		logic match;
		logic last;
		logic filled_next;
		logic out_free;
	} sts_t;

endpackage

@@ rtl/core/sensor_running_average_monitor.sv @@
// ----------------------------------------------------------------------------
// sensor_running_average_monitor
// Sensor table with per-sensor moving-average window and threshold check.
// ----------------------------------------------------------------------------
// add item: table entry written and ring state cleared unless full, then result;
// measurement: entries scanned (read, compare), ring state and old sample of the
// hit entry read, ring and sum updated, and with a full window a reciprocal
// multiply divides the biased sum; unknown id: all entries scanned, none if empty;
// a stalled result holds the block in its output step; one item in flight
// reset: table empty, thresholds at 18.0 and 25.0 degrees, no item pending
module sensor_running_average_monitor import sravm_pkg::*; #(
	parameter int MAX_SENSORS = DEF_MAX_SENSORS,
	parameter int WINDOW      = DEF_WINDOW
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     action,
	input  logic [DATA_W-1:0]        sensor,
	input  logic [DATA_W-1:0]        room_id,
	input  logic signed [DATA_W-1:0] temperature,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [2:0]               status,
	output logic [DATA_W-1:0]        sensor_out,
	output logic [DATA_W-1:0]        room_out,
	output logic signed [DATA_W-1:0] average,
	output logic                     window_full,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_W-1:0]    paddr,
	input  logic [CFG_DATA_W-1:0]    pwdata,
	output logic [CFG_DATA_W-1:0]    prdata,
	output logic                     pready
);

	logic [DATA_W-1:0] min_temp_q, max_temp_q, rd_val;
	logic              cfg_wr;
	cmd_t              cmd;
	sts_t              sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_temp_q <= MIN_TEMP_RST;
			max_temp_q <= MAX_TEMP_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_MIN_TEMP: min_temp_q <= pwdata[DATA_W-1:0];
				REG_MAX_TEMP: max_temp_q <= pwdata[DATA_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MIN_TEMP: rd_val = min_temp_q;
			REG_MAX_TEMP: rd_val = max_temp_q;
			default:      rd_val = '0;
		endcase
	end

	assign prdata = {{(CFG_DATA_W - DATA_W){1'b0}}, rd_val};

	sravm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.busy     (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	sravm_dp #(
		.MAX_SENSORS (MAX_SENSORS),
		.WINDOW      (WINDOW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.action      (action),
		.sensor      (sensor),
		.room_id     (room_id),
		.temperature (temperature),
		.min_temp    (min_temp_q),
		.max_temp    (max_temp_q),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.sensor_out  (sensor_out),
		.room_out    (room_out),
		.average     (average),
		.window_full (window_full)
	);

endmodule

@@ rtl/core/sravm_ram.sv @@
// ----------------------------------------------------------------------------
// sravm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sravm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/sravm_ctrl.sv @@
// ----------------------------------------------------------------------------
// sravm_ctrl
// Sequencer of the monitor: table add and scan, ring update, divide and result
// hand-off, driving the datapath through one command bundle.
// ----------------------------------------------------------------------------
module sravm_ctrl import sravm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic busy,
	input  sts_t sts,
	output cmd_t cmd
);

	ctl_state_t           state_q, state_d;
	res_t                 res_q, res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			res_q     <= RES_ADDED;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	// next state and result code
	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (sts.action == ACT_ADD) ? S_ADD : S_SCAN_RD;
				end
			end
			S_ADD: begin
				res_d   = sts.full ? RES_FULL : RES_ADDED;
				state_d = S_OUT;
			end
			S_SCAN_RD: begin
				if (sts.count_zero) begin
					res_d   = RES_UNKNOWN;
					state_d = S_OUT;
				end else begin
					state_d = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				if (sts.match) begin
					state_d = S_RD_ST;
				end else if (sts.last) begin
					res_d   = RES_UNKNOWN;
					state_d = S_OUT;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_RD_ST:  state_d = S_RD_SMP;
			S_RD_SMP: state_d = S_UPD;
			S_UPD: begin
				if (sts.filled_next) begin
					state_d = S_DIV_INIT;
				end else begin
					res_d   = RES_WARMUP;
					state_d = S_OUT;
				end
			end
			S_DIV_INIT: state_d = S_DIV;
			S_DIV: begin
				res_d   = RES_AVG;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		cmd.res  = res_q;
		busy     = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy        = 1'b0;
				cmd.capture = in_valid;
			end
			S_ADD:      cmd.add_write = !sts.full;
			S_SCAN_RD:  ;
			S_SCAN_CMP: begin
				cmd.take_room = sts.match;
				cmd.scan_next = !sts.match && !sts.last;
			end
			S_RD_ST:    cmd.take_state = 1'b1;
			S_RD_SMP:   ;
			S_UPD:      cmd.upd = 1'b1;
			S_DIV_INIT: cmd.div_init = 1'b1;
			S_DIV:      cmd.div_step = 1'b1;
			S_OUT:      cmd.load_out = sts.out_free;
			default:    ;
		endcase
	end

endmodule

@@ rtl/core/sravm_dp.sv @@
// ----------------------------------------------------------------------------
// sravm_dp
// Datapath of the monitor: sensor table, per-entry ring state, sample RAM,
// window sum update, reciprocal-multiply floor divide, threshold compare,
// output regs.
// ----------------------------------------------------------------------------
module sravm_dp import sravm_pkg::*; #(
	parameter int MAX_SENSORS = DEF_MAX_SENSORS,
	parameter int WINDOW      = DEF_WINDOW
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     action,
	input  logic [DATA_W-1:0]        sensor,
	input  logic [DATA_W-1:0]        room_id,
	input  logic signed [DATA_W-1:0] temperature,
	input  logic signed [DATA_W-1:0] min_temp,
	input  logic signed [DATA_W-1:0] max_temp,
	input  cmd_t                     cmd,
	output sts_t                     sts,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [2:0]               status,
	output logic [DATA_W-1:0]        sensor_out,
	output logic [DATA_W-1:0]        room_out,
	output logic signed [DATA_W-1:0] average,
	output logic                     window_full
);

	localparam int IDX_W  = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
	localparam int CNT_W  = $clog2(MAX_SENSORS + 1);
	localparam int WB     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int POS_W  = WB;
	localparam int SUM_W  = DATA_W + WB;
	localparam int SLOTS  = MAX_SENSORS * WINDOW;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ST_W   = POS_W + 1 + SUM_W;
	localparam int TBL_W  = 2 * DATA_W;
	// bias that makes any window sum non-negative before the divide
	localparam int OFFSET = (1 << (DATA_W - 1)) * WINDOW;
	// ceil(2^RCP_SH / WINDOW) gives the exact floor quotient below 2^SUM_W
	localparam int RCP_SH = SUM_W + WB;
	localparam int RCP_W  = SUM_W + 2;
	localparam int PROD_W = SUM_W + RCP_W;
	localparam logic [RCP_W-1:0] RCP_M =
		RCP_W'(((longint'(1) << RCP_SH) + longint'(WINDOW) - 1) / longint'(WINDOW));

	logic                     action_q;
	logic [DATA_W-1:0]        sid_q, room_in_q, room_q;
	logic signed [DATA_W-1:0] temp_q;
	logic [CNT_W-1:0]         count_q;
	logic [IDX_W-1:0]         idx_q, add_idx;
	logic [POS_W-1:0]         pos_q, pos_next;
	logic                     filled_q, filled_next;
	logic signed [SUM_W-1:0]  sum_q, sum_next, old_smp;
	logic [SUM_W-1:0]         biased, div_n_q;
	logic [PROD_W-1:0]        prod;
	logic [DATA_W-1:0]        div_q_q;
	logic signed [DATA_W-1:0] avg;
	logic [SLOT_W-1:0]        slot;
	logic [TBL_W-1:0]         tbl_rd;
	logic [ST_W-1:0]          st_rd, st_wdata;
	logic                     st_we;
	logic [IDX_W-1:0]         st_waddr;
	logic signed [DATA_W-1:0] smp_rd;
	logic                     out_valid_q;
	status_t                  status_d, cmp_status;
	logic [DATA_W-1:0]        room_d;

	assign add_idx = count_q[IDX_W-1:0];
	assign slot    = SLOT_W'(SLOT_W'(idx_q) * SLOT_W'(WINDOW)) + SLOT_W'(pos_q);

	sravm_ram #(.WIDTH(TBL_W), .DEPTH(MAX_SENSORS)) u_tbl_ram (
		.clk   (clk),
		.we    (cmd.add_write),
		.waddr (add_idx),
		.wdata ({sid_q, room_in_q}),
		.raddr (idx_q),
		.rdata (tbl_rd)
	);

	assign st_we    = cmd.add_write | cmd.upd;
	assign st_waddr = cmd.add_write ? add_idx : idx_q;
	assign st_wdata = cmd.add_write ? '0 : {pos_next, filled_next, sum_next};

	sravm_ram #(.WIDTH(ST_W), .DEPTH(MAX_SENSORS)) u_st_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (idx_q),
		.rdata (st_rd)
	);

	sravm_ram #(.WIDTH(DATA_W), .DEPTH(SLOTS)) u_smp_ram (
		.clk   (clk),
		.we    (cmd.upd),
		.waddr (slot),
		.wdata (temp_q),
		.raddr (slot),
		.rdata (smp_rd)
	);

	// ring advance and window sum update
	assign pos_next    = (pos_q == POS_W'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
	assign filled_next = filled_q | (pos_q == POS_W'(WINDOW - 1));
	assign old_smp     = filled_q ? SUM_W'(smp_rd) : '0;
	assign sum_next    = sum_q - old_smp + SUM_W'(temp_q);

	assign biased = $unsigned(sum_q) + SUM_W'(OFFSET);

	// floor divide by WINDOW as a multiply by the rounded-up reciprocal
	assign prod = PROD_W'(div_n_q) * PROD_W'(RCP_M);

	// remove the bias again
	assign avg = {~div_q_q[DATA_W-1], div_q_q[DATA_W-2:0]};

	always_comb begin
		if (avg < min_temp) begin
			cmp_status = ST_COLD;
		end else if (avg > max_temp) begin
			cmp_status = ST_HOT;
		end else begin
			cmp_status = ST_NORMAL;
		end
	end

	always_comb begin
		unique case (cmd.res)
			RES_ADDED: begin
				status_d = ST_ADDED;
				room_d   = room_in_q;
			end
			RES_FULL: begin
				status_d = ST_FULL;
				room_d   = '0;
			end
			RES_UNKNOWN: begin
				status_d = ST_UNKNOWN;
				room_d   = '0;
			end
			RES_WARMUP: begin
				status_d = ST_NORMAL;
				room_d   = room_q;
			end
			RES_AVG: begin
				status_d = cmp_status;
				room_d   = room_q;
			end
			default: begin
				status_d = ST_NORMAL;
				room_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.add_write) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.capture) begin
				idx_q <= '0;
			end else if (cmd.scan_next) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q  <= action;
			sid_q     <= sensor;
			room_in_q <= room_id;
			temp_q    <= temperature;
		end
		if (cmd.take_room) begin
			room_q <= tbl_rd[DATA_W-1:0];
		end
		if (cmd.take_state) begin
			{pos_q, filled_q, sum_q} <= st_rd;
		end else if (cmd.upd) begin
			sum_q <= sum_next;
		end
		if (cmd.div_init) begin
			div_n_q <= biased;
		end
		if (cmd.div_step) begin
			div_q_q <= prod[RCP_SH +: DATA_W];
		end
		if (cmd.load_out) begin
			status      <= status_d;
			sensor_out  <= sid_q;
			room_out    <= room_d;
			average     <= (cmd.res == RES_AVG) ? avg : '0;
			window_full <= (cmd.res == RES_AVG);
		end
	end

	assign out_valid       = out_valid_q;
	assign sts.action      = action;
	assign sts.full        = (count_q == CNT_W'(MAX_SENSORS));
	assign sts.count_zero  = (count_q == '0);
	assign sts.match       = (tbl_rd[TBL_W-1:DATA_W] == sid_q) && !action_q ? 1'b0 :
	                         (tbl_rd[TBL_W-1:DATA_W] == sid_q);
	assign sts.last        = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign sts.filled_next = filled_next;
	assign sts.out_free    = !out_valid_q || !out_stall;

endmodule

@@ rtl/core/sravm_checker.sv @@
// ----------------------------------------------------------------------------
// sravm_checker
// Port-level checks of the monitor, bound to the top level.
// ----------------------------------------------------------------------------
module sravm_checker import sravm_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [2:0]               status,
	input logic [DATA_W-1:0]        sensor_out,
	input logic [DATA_W-1:0]        room_out,
	input logic signed [DATA_W-1:0] average,
	input logic                     window_full
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(sensor_out)
			&& $stable(room_out) && $stable(average) && $stable(window_full))
		else $error("stalled result changed");

	// one item at a time: busy right after an item is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item accepted while busy");

	a_added_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ADDED |-> average == '0 && !window_full)
		else $error("add result carries window data");

	a_refused_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_UNKNOWN || status == ST_FULL)
			|-> room_out == '0 && average == '0 && !window_full)
		else $error("refused item carries entry data");

	// a threshold flag needs a full window
	a_flag_needs_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_COLD || status == ST_HOT) |-> window_full)
		else $error("threshold flag before window full");

endmodule

bind sensor_running_average_monitor sravm_checker u_sravm_checker (.*);
